// ===== hdl/ocfv_pkg.sv =====
// ----------------------------------------------------------------------------
// ocfv_pkg
// Shared types and constants for the opposite-corner solver: word layouts,
// coordinate format and configuration register indexes.
// ----------------------------------------------------------------------------
package ocfv_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_XVAN_U = 3'd0,
        REG_XVAN_V = 3'd1,
        REG_XVAN_W = 3'd2,
        REG_ZVAN_U = 3'd3,
        REG_ZVAN_V = 3'd4,
        REG_ZVAN_W = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_u;
        logic signed [COORD_BITS-1:0] first_v;
        logic signed [COORD_BITS-1:0] far_u;
        logic signed [COORD_BITS-1:0] far_v;
    } pair_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] side_a_u;
        logic signed [COORD_BITS-1:0] side_a_v;
        logic signed [COORD_BITS-1:0] side_b_u;
        logic signed [COORD_BITS-1:0] side_b_v;
        logic                         side_a_infinite;
        logic                         side_b_infinite;
        logic                         clipped;
    } box_t;

endpackage

// ===== hdl/opposite_corners_from_vanishing.sv =====
// ----------------------------------------------------------------------------
// opposite_corners_from_vanishing
// Recovers the two missing rectangle corners from two opposite corners and
// the x and z vanishing points, by homogeneous line intersection.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  pair    | in        | pair_valid/pair_stall | ocfv_pkg::pair_t
//  box     | out       | box_valid/box_stall   | ocfv_pkg::box_t
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  One pair enters per cycle unless pair_stall is high; each word then
//  passes through the bit-per-stage restoring dividers before it leaves.
//  Each pipeline stage holds on its own while a later stage is full and
//  stalled, so bubbles collapse and nothing is lost or repeated.
//  Reset clears the stage valid bits and loads the vanishing points to
//  (0, 0, 1.0); cfg_ready is always high.
// ----------------------------------------------------------------------------
module opposite_corners_from_vanishing #(
    parameter int FRAC_BITS = ocfv_pkg::FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pair_valid,
    output logic                                  pair_stall,
    input  ocfv_pkg::pair_t                       pair,
    output logic                                  box_valid,
    input  logic                                  box_stall,
    output ocfv_pkg::box_t                        box,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  ocfv_pkg::cfg_index_t                  cfg_index,
    input  logic signed [ocfv_pkg::COORD_BITS-1:0] cfg_data
);

    localparam int C   = ocfv_pkg::COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int LW  = 2*C + 1;
    localparam int PRW = 4*C + 2;
    localparam int PW  = 4*C + 3;
    localparam int NW  = PW + F + 2;
    localparam int RW  = NW + C + 1;
    localparam int QB  = C;
    localparam int NST = 10 + QB;
    localparam int OUT = NST - 1;

    localparam logic signed [C-1:0] ONE  = C'(64'd1 << F);
    localparam logic [C-1:0]        HALF = C'(64'd1 << (C-1));

    localparam int AI [6] = '{1, 2, 2, 0, 0, 1};
    localparam int BI [6] = '{2, 1, 0, 2, 1, 0};

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] den;
        logic [QB-1:0] q;
        logic          neg;
        logic          inf;
        logic          over;
    } dv_t;

    logic signed [C-1:0]     van_reg [2][3];
    logic [NST-1:0]          vld_reg;
    logic [NST-1:0]          en;

    logic signed [C-1:0]     pt_reg  [4];
    logic signed [2*C-1:0]   m1_reg  [4][6];
    logic signed [2*C-1:0]   m1_next [4][6];
    logic signed [LW-1:0]    ln_reg  [4][3];
    logic signed [LW-1:0]    ln_next [4][3];
    logic signed [2*C+1:0]   hh_reg  [2][6];
    logic signed [2*C+1:0]   hl_reg  [2][6];
    logic signed [2*C+1:0]   lh_reg  [2][6];
    logic [2*C-1:0]          ll_reg  [2][6];
    logic signed [2*C+1:0]   hh_next [2][6];
    logic signed [2*C+1:0]   hl_next [2][6];
    logic signed [2*C+1:0]   lh_next [2][6];
    logic [2*C-1:0]          ll_next [2][6];
    logic signed [PRW-1:0]   m2_reg  [2][6];
    logic signed [PRW-1:0]   m2_next [2][6];
    logic signed [PW-1:0]    hp_reg  [2][3];
    logic signed [PW-1:0]    hp_next [2][3];
    logic [PW-1:0]           mag_reg [2][3];
    logic [PW-1:0]           mag_next[2][3];
    logic                    sgn_reg [2][3];
    logic                    wz_reg  [2];
    dv_t                     st7_reg [4];
    dv_t                     st7_next[4];
    dv_t                     dv_reg  [QB+1][4];
    dv_t                     dv_next [QB+1][4];
    ocfv_pkg::box_t          box_reg;
    ocfv_pkg::box_t          box_next;

    assign cfg_ready  = 1'b1;
    assign pair_stall = !en[0];
    assign box_valid  = vld_reg[OUT];
    assign box        = box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 2; t++)
            begin
                van_reg[t][0] <= '0;
                van_reg[t][1] <= '0;
                van_reg[t][2] <= ONE;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ocfv_pkg::REG_XVAN_U: van_reg[0][0] <= cfg_data;
                ocfv_pkg::REG_XVAN_V: van_reg[0][1] <= cfg_data;
                ocfv_pkg::REG_XVAN_W: van_reg[0][2] <= cfg_data;
                ocfv_pkg::REG_ZVAN_U: van_reg[1][0] <= cfg_data;
                ocfv_pkg::REG_ZVAN_V: van_reg[1][1] <= cfg_data;
                ocfv_pkg::REG_ZVAN_W: van_reg[1][2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || !box_stall;
        for (int i = NST-2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= pair_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // lines through each corner and each vanishing point
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            m1_next[l][0] = van_reg[l%2][1] * ONE;
            m1_next[l][1] = van_reg[l%2][2] * pt_reg[2*(l/2)+1];
            m1_next[l][2] = van_reg[l%2][2] * pt_reg[2*(l/2)];
            m1_next[l][3] = van_reg[l%2][0] * ONE;
            m1_next[l][4] = van_reg[l%2][0] * pt_reg[2*(l/2)+1];
            m1_next[l][5] = van_reg[l%2][1] * pt_reg[2*(l/2)];
            for (int i = 0; i < 3; i++)
            begin
                ln_next[l][i] = LW'(m1_reg[l][2*i]) - LW'(m1_reg[l][2*i+1]);
            end
        end
    end

    // corner 0 is z2 x x0, corner 1 is z0 x x2
    always_comb
    begin
        logic signed [LW-1:0] a;
        logic signed [LW-1:0] b;
        for (int c = 0; c < 2; c++)
        begin
            for (int j = 0; j < 6; j++)
            begin
                a = ln_reg[(c == 0) ? 3 : 1][AI[j]];
                b = ln_reg[(c == 0) ? 0 : 2][BI[j]];
                hh_next[c][j] = $signed(a[LW-1:C]) * $signed(b[LW-1:C]);
                hl_next[c][j] = $signed(a[LW-1:C]) * $signed({1'b0, b[C-1:0]});
                lh_next[c][j] = $signed({1'b0, a[C-1:0]}) * $signed(b[LW-1:C]);
                ll_next[c][j] = a[C-1:0] * b[C-1:0];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int j = 0; j < 6; j++)
            begin
                m2_next[c][j] = (PRW'(hh_reg[c][j]) <<< (2*C))
                              + ((PRW'(hl_reg[c][j]) + PRW'(lh_reg[c][j])) <<< C)
                              + $signed(PRW'(ll_reg[c][j]));
            end
            for (int i = 0; i < 3; i++)
            begin
                hp_next[c][i] = PW'(m2_reg[c][2*i]) - PW'(m2_reg[c][2*i+1]);
                mag_next[c][i] = hp_reg[c][i][PW-1] ? PW'(-hp_reg[c][i])
                                                    : PW'(hp_reg[c][i]);
            end
        end
    end

    // rounded dehomogenizing division, one quotient bit per stage
    always_comb
    begin
        logic [RW-1:0] t;
        for (int k = 0; k < 4; k++)
        begin
            st7_next[k].rem  = (RW'(mag_reg[k/2][k%2]) << (F+1)) + RW'(mag_reg[k/2][2]);
            st7_next[k].den  = RW'(mag_reg[k/2][2]) << 1;
            st7_next[k].q    = '0;
            st7_next[k].neg  = sgn_reg[k/2][k%2] ^ sgn_reg[k/2][2];
            st7_next[k].inf  = wz_reg[k/2];
            st7_next[k].over = 1'b0;
            dv_next[0][k]      = st7_reg[k];
            dv_next[0][k].over = st7_reg[k].rem >= (st7_reg[k].den << QB);
            for (int j = 0; j < QB; j++)
            begin
                dv_next[j+1][k] = dv_reg[j][k];
                t = dv_reg[j][k].den << (QB-1-j);
                if (dv_reg[j][k].rem >= t)
                begin
                    dv_next[j+1][k].rem         = dv_reg[j][k].rem - t;
                    dv_next[j+1][k].q[QB-1-j]   = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [C-1:0] lim;
        logic [C-1:0] qv;
        logic [C-1:0] val [4];
        logic         clip;
        clip = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            lim = dv_reg[QB][k].neg ? HALF : HALF - C'(1);
            qv  = dv_reg[QB][k].q;
            if (dv_reg[QB][k].inf)
            begin
                qv = '0;
            end
            else if (dv_reg[QB][k].over || qv > lim)
            begin
                qv   = lim;
                clip = 1'b1;
            end
            val[k] = (dv_reg[QB][k].neg && !dv_reg[QB][k].inf) ? C'(-qv) : qv;
        end
        box_next.side_a_u        = $signed(val[0]);
        box_next.side_a_v        = $signed(val[1]);
        box_next.side_b_u        = $signed(val[2]);
        box_next.side_b_v        = $signed(val[3]);
        box_next.side_a_infinite = dv_reg[QB][0].inf;
        box_next.side_b_infinite = dv_reg[QB][2].inf;
        box_next.clipped         = clip;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pt_reg[0] <= pair.first_u;
            pt_reg[1] <= pair.first_v;
            pt_reg[2] <= pair.far_u;
            pt_reg[3] <= pair.far_v;
        end
        if (en[1])
        begin
            m1_reg <= m1_next;
        end
        if (en[2])
        begin
            ln_reg <= ln_next;
        end
        if (en[3])
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
        if (en[4])
        begin
            m2_reg <= m2_next;
        end
        if (en[5])
        begin
            hp_reg <= hp_next;
        end
        if (en[6])
        begin
            mag_reg <= mag_next;
            for (int c = 0; c < 2; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sgn_reg[c][i] <= hp_reg[c][i][PW-1];
                end
                wz_reg[c] <= (hp_reg[c][2] == '0);
            end
        end
        if (en[7])
        begin
            st7_reg <= st7_next;
        end
        for (int j = 0; j <= QB; j++)
        begin
            if (en[8+j])
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
        if (en[OUT])
        begin
            box_reg <= box_next;
        end
    end

endmodule

// ===== hdl/ocfv_checker.sv =====
// ----------------------------------------------------------------------------
// ocfv_checker
// Port-level checks for the opposite-corner solver, bound to the top level.
// ----------------------------------------------------------------------------
module ocfv_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pair_stall,
    input logic           box_valid,
    input logic           box_stall,
    input ocfv_pkg::box_t box
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_stall |=> box_valid && $stable(box))
        else $error("box word changed while stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !box_valid |-> !pair_stall)
        else $error("pair stalled with empty output");

    a_inf_a: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box.side_a_infinite |-> box.side_a_u == '0 && box.side_a_v == '0)
        else $error("infinite side a not zeroed");

    a_inf_b: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box.side_a_infinite && box.side_b_infinite |-> !box.clipped)
        else $error("clip raised with both corners at infinity");

endmodule

bind opposite_corners_from_vanishing ocfv_checker u_ocfv_checker (.*);
